>>> design/mlfr_pkg.sv
// shared types, constants and helpers of the multi-link frame receiver
package mlfr_pkg;

  localparam int LINKS      = 4;
  localparam int LINK_W     = (LINKS > 1) ? $clog2(LINKS) : 1;
  localparam int HEADER_LEN = 6;
  localparam int CNT_W      = 17;
  localparam int LEN_W      = 16;
  localparam int MASK_W     = 16;
  localparam int LIDX_W     = 4;
  localparam int SEL_W      = 5;
  localparam int CIDX_W     = 8;
  localparam int CDATA_W    = 16;
  localparam int OUT_TDATA_W = 64;

  // register indexes on the configuration channel
  localparam logic [CIDX_W-1:0] CFG_HEAD_BYTE    = 8'd0;
  localparam logic [CIDX_W-1:0] CFG_MY_DEVICE_ID = 8'd1;
  localparam logic [CIDX_W-1:0] CFG_BROADCAST_ID = 8'd2;
  localparam logic [CIDX_W-1:0] CFG_MAX_DATA_LEN = 8'd3;

  // frame identifiers and payload markers used for dispatch class
  localparam logic [7:0] ID_ZERO  = 8'h00;
  localparam logic [7:0] ID_C0    = 8'hC0;
  localparam logic [7:0] ID_C1    = 8'hC1;
  localparam logic [7:0] ID_E0    = 8'hE0;
  localparam logic [7:0] ID_E1    = 8'hE1;
  localparam logic [7:0] FIRST_C0 = 8'hC0;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_HEADER = 3'd1,
    PH_DATA   = 3'd2,
    PH_SUM    = 3'd3,
    PH_ADD    = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_GOOD     = 3'd1,
    EV_CHK_FAIL = 3'd2,
    EV_LEN_DROP = 3'd3,
    EV_IGNORED  = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    CLS_GENERIC = 2'd0,
    CLS_ZERO_C0 = 2'd1,
    CLS_COMMAND = 2'd2,
    CLS_PARAM   = 2'd3
  } class_e;

  typedef struct packed {
    logic [7:0]       head_byte;
    logic [7:0]       my_device_id;
    logic [7:0]       broadcast_id;
    logic [LEN_W-1:0] max_data_len;
  } cfg_t;

  typedef struct packed {
    phase_e           phase;
    logic [CNT_W-1:0] byte_count;
    logic [7:0]       running_sum;
    logic [7:0]       running_add;
    logic [7:0]       frame_dest;
    logic [7:0]       frame_ident;
    logic [LEN_W-1:0] payload_len;
    logic [7:0]       first_payload;
  } link_state_t;

  typedef struct packed {
    logic [LIDX_W-1:0] link_index;
    logic              in_frame;
    logic              payload_valid;
    logic [LEN_W-1:0]  payload_offset;
    event_e            event_res;
    logic              deliver_local;
    logic              forward;
    class_e            frame_class;
    logic [7:0]        frame_id;
    logic [7:0]        dest_id;
    logic [LEN_W-1:0]  data_length;
  } result_t;

  // index of the lowest set bit, MASK_W when no bit is set
  function automatic logic [SEL_W-1:0] lowest_set(input logic [MASK_W-1:0] mask);
    logic [SEL_W-1:0] idx;
    idx = SEL_W'(MASK_W);
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (mask[i]) idx = SEL_W'(i);
    end
    return idx;
  endfunction

endpackage

>>> design/mlfr_cfg.sv
// configuration register file of the frame receiver
module mlfr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [mlfr_pkg::CIDX_W-1:0]   wr_index_i,
  input  logic [mlfr_pkg::CDATA_W-1:0]  wr_data_i,
  output mlfr_pkg::cfg_t                cfg_o
);
  import mlfr_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_byte    <= 8'hAB;
      cfg_q.my_device_id <= 8'h00;
      cfg_q.broadcast_id <= 8'hFF;
      cfg_q.max_data_len <= LEN_W'(300);
    end else if (wr_en_i) begin
      case (wr_index_i)
        CFG_HEAD_BYTE:    cfg_q.head_byte    <= wr_data_i[7:0];
        CFG_MY_DEVICE_ID: cfg_q.my_device_id <= wr_data_i[7:0];
        CFG_BROADCAST_ID: cfg_q.broadcast_id <= wr_data_i[7:0];
        CFG_MAX_DATA_LEN: cfg_q.max_data_len <= wr_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/mlfr_parser.sv
// one step of a link's frame parser: next link state and the result of one byte
module mlfr_parser (
  input  mlfr_pkg::link_state_t st_i,
  input  mlfr_pkg::cfg_t        cfg_i,
  input  logic [7:0]            byte_i,
  output mlfr_pkg::link_state_t st_o,
  output mlfr_pkg::result_t     res_o
);
  import mlfr_pkg::*;

  logic [7:0]       sum_add;
  logic [7:0]       add_add;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] data_end;
  logic [LEN_W-1:0] data_off;
  class_e           cls;

  assign sum_add  = st_i.running_sum + byte_i;
  assign add_add  = st_i.running_add + sum_add;
  assign cnt_inc  = st_i.byte_count + CNT_W'(1);
  assign data_end = CNT_W'(HEADER_LEN) + {1'b0, st_i.payload_len};
  assign data_off = LEN_W'(st_i.byte_count - CNT_W'(HEADER_LEN));

  always_comb begin
    if (st_i.frame_ident == ID_ZERO) begin
      cls = (st_i.payload_len != '0 && st_i.first_payload == FIRST_C0) ?
            CLS_ZERO_C0 : CLS_GENERIC;
    end else if (st_i.frame_ident == ID_C0 || st_i.frame_ident == ID_C1) begin
      cls = CLS_COMMAND;
    end else if (st_i.frame_ident == ID_E0 || st_i.frame_ident == ID_E1) begin
      cls = CLS_PARAM;
    end else begin
      cls = CLS_GENERIC;
    end
  end

  always_comb begin
    logic report;
    report = 1'b0;
    st_o   = st_i;
    res_o  = '0;
    case (st_i.phase)
      PH_HUNT: begin
        if (byte_i == cfg_i.head_byte) begin
          st_o             = '0;
          st_o.phase       = PH_HEADER;
          st_o.byte_count  = CNT_W'(1);
          st_o.running_sum = byte_i;
          st_o.running_add = byte_i;
          res_o.in_frame   = 1'b1;
        end
      end
      PH_HEADER: begin
        res_o.in_frame   = 1'b1;
        st_o.running_sum = sum_add;
        st_o.running_add = add_add;
        st_o.byte_count  = cnt_inc;
        case (st_i.byte_count)
          CNT_W'(2): st_o.frame_dest  = byte_i;
          CNT_W'(3): st_o.frame_ident = byte_i;
          CNT_W'(4): st_o.payload_len = {st_i.payload_len[15:8], byte_i};
          CNT_W'(5): st_o.payload_len = {byte_i, st_i.payload_len[7:0]};
          default: ;
        endcase
        if (cnt_inc >= CNT_W'(HEADER_LEN)) begin
          if (st_o.payload_len >= cfg_i.max_data_len) begin
            st_o.phase      = PH_HUNT;
            res_o.event_res = EV_LEN_DROP;
            report          = 1'b1;
          end else if (st_o.payload_len == '0) begin
            st_o.phase = PH_SUM;
          end else begin
            st_o.phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        res_o.in_frame       = 1'b1;
        res_o.payload_valid  = 1'b1;
        res_o.payload_offset = data_off;
        if (data_off == '0) st_o.first_payload = byte_i;
        st_o.running_sum = sum_add;
        st_o.running_add = add_add;
        st_o.byte_count  = cnt_inc;
        if (cnt_inc >= data_end) st_o.phase = PH_SUM;
      end
      PH_SUM: begin
        res_o.in_frame   = 1'b1;
        st_o.running_sum = st_i.running_sum ^ byte_i;
        st_o.phase       = PH_ADD;
      end
      PH_ADD: begin
        res_o.in_frame = 1'b1;
        st_o.phase     = PH_HUNT;
        report         = 1'b1;
        if (st_i.running_sum == '0 && st_i.running_add == byte_i) begin
          res_o.event_res     = EV_GOOD;
          res_o.deliver_local = (st_i.frame_dest == cfg_i.my_device_id) ||
                                (st_i.frame_dest == cfg_i.broadcast_id);
          res_o.forward       = (st_i.frame_dest != cfg_i.my_device_id);
          res_o.frame_class   = cls;
        end else begin
          res_o.event_res = EV_CHK_FAIL;
        end
      end
      default: begin
        st_o.phase = PH_HUNT;
      end
    endcase
    if (report) begin
      res_o.frame_id    = st_o.frame_ident;
      res_o.dest_id     = st_o.frame_dest;
      res_o.data_length = st_o.payload_len;
    end
  end

endmodule

>>> design/multi_link_frame_receiver_unit.sv
// top level of the multi-link frame receiver: input stage, link state bank, result stage
//
// channel   dir  transfer when            payload
// s_axis    in   tvalid & tready          tuser: link_mask, tdata: data_byte
// m_axis    out  tvalid & tready          tuser: link_index, tdata: result fields
// cfg       in   cfg_valid_i & cfg_ready_o register index and write data
//
// one byte per cycle sustained while results are taken; each byte passes through the input
// register and then the result register, moving on only when the result register frees up
// the per-link state is read and updated combinationally between the two registers and
// written back as the byte moves on, so back-to-back bytes on one link need no bypass
// reset puts every link in head hunt and loads the register reset values
// a stalled result holds the result register; the input register fills behind it,
// then s_axis_tready drops until the result is taken
module multi_link_frame_receiver_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // byte input
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
  input  logic [mlfr_pkg::MASK_W-1:0]    s_axis_tuser,   // [15:0] link_mask
  // result output
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] in_frame, [1] payload_valid, [17:2] payload_offset, [20:18] event_res,
  // [21] deliver_local, [22] forward, [24:23] frame_class, [32:25] frame_id,
  // [40:33] dest_id, [56:41] data_length, [63:57] zero
  output logic [mlfr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [mlfr_pkg::LIDX_W-1:0]    m_axis_tuser,   // [3:0] link_index
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mlfr_pkg::CIDX_W-1:0]    cfg_index_i,
  input  logic [mlfr_pkg::CDATA_W-1:0]   cfg_data_i
);
  import mlfr_pkg::*;

  cfg_t cfg;

  // input stage
  logic              in_vld_q;
  logic [MASK_W-1:0] mask_q;
  logic [7:0]        byte_q;

  // result stage
  logic    out_vld_q;
  result_t res_q;

  // per-link parser state
  link_state_t link_q [LINKS];

  logic              advance;
  logic              fire;
  logic [SEL_W-1:0]  sel_idx;
  logic              link_ok;
  logic [LINK_W-1:0] link_sel;
  link_state_t       st_cur;
  link_state_t       st_nxt;
  result_t           step_res;
  result_t           res_d;

  assign cfg_ready_o = 1'b1;

  mlfr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // the result register frees up whenever it is empty or being taken
  assign advance       = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  // lowest set mask bit picks the link; out of range or no bit drops the byte
  assign sel_idx  = lowest_set(mask_q);
  assign link_ok  = (sel_idx < SEL_W'(LINKS));
  assign link_sel = sel_idx[LINK_W-1:0];
  assign st_cur   = link_q[link_sel];

  mlfr_parser u_parser (
    .st_i   (st_cur),
    .cfg_i  (cfg),
    .byte_i (byte_q),
    .st_o   (st_nxt),
    .res_o  (step_res)
  );

  always_comb begin
    if (link_ok) begin
      res_d            = step_res;
      res_d.link_index = sel_idx[LIDX_W-1:0];
    end else begin
      res_d            = '0;
      res_d.event_res  = EV_IGNORED;
      res_d.link_index = (sel_idx < SEL_W'(MASK_W)) ? sel_idx[LIDX_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mask_q <= s_axis_tuser;
      byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LINKS; i++) begin
        link_q[i] <= '0;
      end
    end else if (fire && link_ok) begin
      link_q[link_sel] <= st_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_q.link_index;
  assign m_axis_tdata  = {
    7'd0,
    res_q.data_length,
    res_q.dest_id,
    res_q.frame_id,
    res_q.frame_class,
    res_q.forward,
    res_q.deliver_local,
    res_q.event_res,
    res_q.payload_offset,
    res_q.payload_valid,
    res_q.in_frame
  };

  // a byte for a link out of range reports ignored and nothing else
  a_ignored_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !link_ok |=> res_q.event_res == EV_IGNORED && !res_q.in_frame)
    else $error("out of range link did not report ignored");

  // a payload byte is always part of a frame
  a_payload_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.payload_valid |-> res_q.in_frame)
    else $error("payload byte flagged outside a frame");

  // dispatch flags only come with a good frame end
  a_dispatch_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (res_q.deliver_local || res_q.forward) |-> res_q.event_res == EV_GOOD)
    else $error("dispatch flag without good frame end");

  // a held input byte is neither lost nor overwritten
  a_input_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(byte_q) && $stable(mask_q))
    else $error("input stage lost or overwrote a waiting byte");

endmodule
